// File: design/tlsu_pkg.sv
package tlsu_pkg;

  localparam int unsigned QDepth = 9;
  localparam int unsigned QIdxW = 4;

  // input op codes
  localparam logic [1:0] OpPreload = 2'd0;
  localparam logic [1:0] OpExec    = 2'd1;
  localparam logic [1:0] OpRdata   = 2'd2;

  // result kinds
  localparam logic [1:0] KindRead  = 2'd0;
  localparam logic [1:0] KindWrite = 2'd1;
  localparam logic [1:0] KindReg   = 2'd2;
  localparam logic [1:0] KindNone  = 2'd3;

  // access sizes
  localparam logic [1:0] SzByte = 2'd0;
  localparam logic [1:0] SzHalf = 2'd1;
  localparam logic [1:0] SzWord = 2'd2;

  // extension codes
  localparam logic [2:0] ExtWord  = 3'd0;
  localparam logic [2:0] ExtByte  = 3'd1;
  localparam logic [2:0] ExtHalf  = 3'd2;
  localparam logic [2:0] ExtSByte = 3'd3;
  localparam logic [2:0] ExtSHalf = 3'd4;
  localparam logic [2:0] ExtPc    = 3'd5;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StOut
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture accepted beat, decode
    logic step;   // produce next result into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;   // output register holds the final result
  } sts_t;

endpackage

// File: design/tlsu_ctrl.sv
module tlsu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_fire_i,
  input  logic          out_fire_i,
  input  tlsu_pkg::sts_t sts_i,
  output tlsu_pkg::cmd_t cmd_o,
  output logic          in_ready_o,
  output logic          out_valid_o
);

  tlsu_pkg::state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tlsu_pkg::StIdle: if (in_fire_i) state_d = tlsu_pkg::StRun;
      tlsu_pkg::StRun:  state_d = tlsu_pkg::StOut;
      tlsu_pkg::StOut: begin
        if (out_fire_i) state_d = sts_i.done ? tlsu_pkg::StIdle : tlsu_pkg::StRun;
      end
      default: state_d = tlsu_pkg::StIdle;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.load  = 1'b0;
    cmd_o.step  = 1'b0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      tlsu_pkg::StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_fire_i;
      end
      tlsu_pkg::StRun: cmd_o.step = 1'b1;
      tlsu_pkg::StOut: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= tlsu_pkg::StIdle;
    else state_q <= state_d;
  end

endmodule

// File: design/tlsu_dp.sv
module tlsu_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tlsu_pkg::cmd_t cmd_i,
  output tlsu_pkg::sts_t sts_o,
  input  logic [1:0]     op_i,
  input  logic [15:0]    ins_i,
  input  logic [3:0]     ridx_i,
  input  logic [31:0]    data_i,
  output logic [1:0]     kind_o,
  output logic [31:0]    addr_o,
  output logic [1:0]     size_o,
  output logic [31:0]    wdata_o,
  output logic [3:0]     rnum_o,
  output logic [31:0]    rval_o,
  output logic           last_o
);

  localparam logic [3:0] RegSp = 4'd13;
  localparam logic [3:0] RegLr = 4'd14;
  localparam logic [3:0] RegPc = 4'd15;

  logic [31:0] rf_q [16];
  logic [6:0]  pq_q [tlsu_pkg::QDepth];
  logic [tlsu_pkg::QIdxW-1:0] cnt_q, head_q;

  // captured beat and multi-transfer state
  logic [1:0]  op_q;
  logic [15:0] ins_q;
  logic [31:0] data_q;
  logic [8:0]  list_q;     // remaining transfers (bit 8 = PC/LR)
  logic [31:0] a_q;        // running address
  logic        base_in_q;
  logic        fin_q;      // only final writeback remains
  logic        done_q;

  logic [31:0] rf_wd;
  logic [3:0]  rf_wa;
  logic        rf_we;
  logic        q_push, q_pop;
  logic [6:0]  q_ent;

  // decode fields
  logic [2:0] rd, rb, ro, rd8;
  logic [4:0] off5;
  logic [7:0] w8;
  logic       lbit;
  assign rd   = ins_q[2:0];
  assign rb   = ins_q[5:3];
  assign ro   = ins_q[8:6];
  assign off5 = ins_q[10:6];
  assign w8   = ins_q[7:0];
  assign rd8  = ins_q[10:8];
  assign lbit = ins_q[11];

  logic [31:0] pcb;
  assign pcb = (rf_q[RegPc] + 32'd2) & ~32'h3;

  logic is_pushpop, is_ldm;
  assign is_pushpop = (ins_q & 16'hF600) == 16'hB400;
  assign is_ldm     = ins_q[15:12] == 4'hC;

  // lowest pending transfer in list
  logic [3:0] lo;
  always_comb begin
    lo = 4'd8;
    for (int i = 7; i >= 0; i--) if (list_q[i]) lo = 4'(i);
  end

  logic [3:0] npop;
  always_comb begin
    npop = {3'd0, ins_q[8]};
    for (int i = 0; i < 8; i++) npop = npop + {3'd0, w8[i]};
  end

  // pending queue read
  logic [6:0] qh;
  logic [31:0] ext;
  assign qh = pq_q[head_q];
  always_comb begin
    unique case (qh[6:4])
      tlsu_pkg::ExtByte:  ext = {24'd0, data_q[7:0]};
      tlsu_pkg::ExtHalf:  ext = {16'd0, data_q[15:0]};
      tlsu_pkg::ExtSByte: ext = {{24{data_q[7]}}, data_q[7:0]};
      tlsu_pkg::ExtSHalf: ext = {{16{data_q[15]}}, data_q[15:0]};
      tlsu_pkg::ExtPc:    ext = data_q & ~32'h1;
      default:            ext = data_q;
    endcase
  end

  // one result per step
  logic [1:0]  k;
  logic [31:0] ad, wd, rv;
  logic [1:0]  sz;
  logic [3:0]  rn;
  logic        lst;
  logic [8:0]  list_d;
  logic [31:0] a_d;
  logic        base_d, fin_d;

  always_comb begin
    k = tlsu_pkg::KindNone; ad = '0; sz = '0; wd = '0; rn = '0; rv = '0; lst = 1'b1;
    rf_we = 1'b0; rf_wa = '0; rf_wd = '0; q_push = 1'b0; q_ent = '0; q_pop = 1'b0;
    list_d = list_q; a_d = a_q; base_d = base_in_q; fin_d = fin_q;
    if (op_q == tlsu_pkg::OpRdata) begin
      if (cnt_q != '0) begin
        k = tlsu_pkg::KindReg; rn = qh[3:0]; rv = ext; q_pop = 1'b1;
      end
    end else if (op_q == tlsu_pkg::OpExec) begin
      priority if (ins_q[15:11] == 5'h09) begin
        k = tlsu_pkg::KindRead; ad = pcb + {22'd0, w8, 2'b0}; sz = tlsu_pkg::SzWord;
        q_push = 1'b1; q_ent = {tlsu_pkg::ExtWord, 1'b0, rd8};
      end else if (ins_q[15:12] == 4'h5 && !ins_q[9]) begin
        ad = rf_q[{1'b0, rb}] + rf_q[{1'b0, ro}];
        sz = ins_q[10] ? tlsu_pkg::SzByte : tlsu_pkg::SzWord;
        if (lbit) begin
          k = tlsu_pkg::KindRead; q_push = 1'b1;
          q_ent = {ins_q[10] ? tlsu_pkg::ExtByte : tlsu_pkg::ExtWord, 1'b0, rd};
        end else begin
          k = tlsu_pkg::KindWrite; wd = rf_q[{1'b0, rd}];
        end
      end else if (ins_q[15:12] == 4'h5) begin
        ad = rf_q[{1'b0, rb}] + rf_q[{1'b0, ro}];
        unique case ({ins_q[10], lbit})
          2'b00: begin k = tlsu_pkg::KindWrite; sz = tlsu_pkg::SzHalf; wd = rf_q[{1'b0, rd}]; end
          2'b01: begin k = tlsu_pkg::KindRead; sz = tlsu_pkg::SzHalf;
                   q_ent = {tlsu_pkg::ExtHalf, 1'b0, rd}; end
          2'b10: begin k = tlsu_pkg::KindRead; sz = tlsu_pkg::SzByte;
                   q_ent = {tlsu_pkg::ExtSByte, 1'b0, rd}; end
          default: begin k = tlsu_pkg::KindRead; sz = tlsu_pkg::SzHalf;
                   q_ent = {tlsu_pkg::ExtSHalf, 1'b0, rd}; end
        endcase
        q_push = (k == tlsu_pkg::KindRead);
      end else if (ins_q[15:13] == 3'h3) begin
        ad = rf_q[{1'b0, rb}] + (ins_q[12] ? {27'd0, off5} : {25'd0, off5, 2'b0});
        sz = ins_q[12] ? tlsu_pkg::SzByte : tlsu_pkg::SzWord;
        if (lbit) begin
          k = tlsu_pkg::KindRead; q_push = 1'b1;
          q_ent = {ins_q[12] ? tlsu_pkg::ExtByte : tlsu_pkg::ExtWord, 1'b0, rd};
        end else begin
          k = tlsu_pkg::KindWrite; wd = rf_q[{1'b0, rd}];
        end
      end else if (ins_q[15:12] == 4'h8) begin
        ad = rf_q[{1'b0, rb}] + {26'd0, off5, 1'b0}; sz = tlsu_pkg::SzHalf;
        if (lbit) begin
          k = tlsu_pkg::KindRead; q_push = 1'b1; q_ent = {tlsu_pkg::ExtHalf, 1'b0, rd};
        end else begin
          k = tlsu_pkg::KindWrite; wd = rf_q[{1'b0, rd}];
        end
      end else if (ins_q[15:12] == 4'h9) begin
        ad = rf_q[RegSp] + {22'd0, w8, 2'b0}; sz = tlsu_pkg::SzWord;
        if (lbit) begin
          k = tlsu_pkg::KindRead; q_push = 1'b1; q_ent = {tlsu_pkg::ExtWord, 1'b0, rd8};
        end else begin
          k = tlsu_pkg::KindWrite; wd = rf_q[{1'b0, rd8}];
        end
      end else if (ins_q[15:12] == 4'hA) begin
        k = tlsu_pkg::KindReg; rn = {1'b0, rd8};
        rv = (lbit ? rf_q[RegSp] : pcb) + {22'd0, w8, 2'b0};
      end else if (ins_q[15:8] == 8'hB0) begin
        k = tlsu_pkg::KindReg; rn = RegSp;
        rv = ins_q[7] ? rf_q[RegSp] - {23'd0, ins_q[6:0], 2'b0}
                      : rf_q[RegSp] + {23'd0, ins_q[6:0], 2'b0};
      end else if (is_pushpop || is_ldm) begin
        lst = 1'b0;
        if (fin_q) begin
          k = tlsu_pkg::KindReg; lst = 1'b1;
          rn = is_ldm ? {1'b0, rd8} : RegSp; rv = a_q;
        end else begin
          ad = a_q; sz = tlsu_pkg::SzWord; a_d = a_q + 32'd4;
          if (lo[3]) list_d = 9'd0;
          else list_d[lo[2:0]] = 1'b0;
          if (lbit) begin
            k = tlsu_pkg::KindRead; q_push = 1'b1;
            q_ent = lo[3] ? {tlsu_pkg::ExtPc, RegPc} : {tlsu_pkg::ExtWord, lo};
            if (is_ldm && lo[2:0] == rd8) base_d = 1'b1;
          end else begin
            k = tlsu_pkg::KindWrite; wd = lo[3] ? rf_q[RegLr] : rf_q[lo];
          end
          if (list_d == 9'd0) begin
            fin_d = 1'b1;
            if (is_ldm && lbit && base_d) lst = 1'b1;
          end
        end
        // push stores final SP, not the running address
        if (fin_q && is_pushpop && !lbit) rv = rf_q[RegSp] - {26'd0, npop, 2'b0};
      end
    end
    if (k == tlsu_pkg::KindReg) begin
      rf_we = 1'b1; rf_wa = rn; rf_wd = rv;
    end
    if (q_push && cnt_q == 4'(tlsu_pkg::QDepth)) q_push = 1'b0;
  end

  logic [3:0] tail;
  always_comb begin
    logic [4:0] s;
    s = {1'b0, head_q} + {1'b0, cnt_q};
    tail = (s >= 5'(tlsu_pkg::QDepth)) ? 4'(s - 5'(tlsu_pkg::QDepth)) : s[3:0];
  end

  // register file, preload and writeback
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) rf_q[i] <= '0;
    end else if (cmd_i.load && op_i == tlsu_pkg::OpPreload) begin
      rf_q[ridx_i] <= data_i;
    end else if (cmd_i.step && rf_we) begin
      rf_q[rf_wa] <= rf_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && q_push) pq_q[tail] <= q_ent;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; head_q <= '0; done_q <= 1'b0;
    end else if (cmd_i.step) begin
      done_q <= lst;
      if (q_push) cnt_q <= cnt_q + 4'd1;
      if (q_pop) begin
        cnt_q <= cnt_q - 4'd1;
        head_q <= (head_q == 4'(tlsu_pkg::QDepth - 1)) ? '0 : head_q + 4'd1;
      end
    end
  end

  // beat capture and transfer sequencing
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i; ins_q <= ins_i; data_q <= data_i; base_in_q <= 1'b0;
      list_q <= {ins_i[15:12] == 4'hB && ins_i[8], ins_i[7:0]};
      fin_q <= ({ins_i[15:12] == 4'hB && ins_i[8], ins_i[7:0]} == 9'd0);
      if ((ins_i & 16'hF600) == 16'hB400 && !ins_i[11]) begin
        a_q <= rf_q[RegSp] - {26'd0, 4'(ins_i[8] + $countones(ins_i[7:0])), 2'b0};
      end else begin
        a_q <= rf_q[ins_i[15:12] == 4'hC ? {1'b0, ins_i[10:8]} : RegSp];
      end
    end else if (cmd_i.step) begin
      list_q <= list_d; a_q <= a_d; base_in_q <= base_d; fin_q <= fin_d;
      kind_o <= k; addr_o <= ad; size_o <= sz; rnum_o <= rn; rval_o <= rv; last_o <= lst;
      unique case (sz)
        tlsu_pkg::SzByte: wdata_o <= {24'd0, wd[7:0]};
        tlsu_pkg::SzHalf: wdata_o <= {16'd0, wd[15:0]};
        default:          wdata_o <= wd;
      endcase
    end
  end

  assign sts_o.done = done_q;

endmodule

// File: design/thumb_load_store_unit_top.sv
// Thumb load/store unit.
// Slave stream carries one beat per item: preload a register, execute a
// Thumb load/store instruction (formats 6 to 15), or return bus read data.
// Master stream carries the result beats: bus read/write requests and
// register writes in ascending order, tlast on the final beat of an item.
// One item at a time: an item is taken, then each result beat is computed
// and then presented before the receiver may take it. PUSH/POP and
// LDMIA/STMIA give one beat per transfer plus one for the writeback,
// except LDMIA with the base in its list, which writes no base back.
// Read requests queue their destination in a 9-entry pending queue;
// returned-data beats pop it oldest-first.
// Reset clears the register file, pending count and state machine.
// If the receiver stalls, the result beat holds and no new item is taken.
module thumb_load_store_unit_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] op, [17:2] instruction, [21:18] reg_index, [53:22] data_word
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] kind, [33:2] address, [35:34] access_size, [67:36] write_data,
  // [71:68] reg_number, [103:72] reg_value
  output logic [103:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  tlsu_pkg::cmd_t cmd;
  tlsu_pkg::sts_t sts;
  logic in_fire, out_fire;
  logic [1:0]  kind, size;
  logic [31:0] addr, wdata, rval;
  logic [3:0]  rnum;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  tlsu_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i(in_fire), .out_fire_i(out_fire), .sts_i(sts), .cmd_o(cmd),
    .in_ready_o(s_axis_tready), .out_valid_o(m_axis_tvalid)
  );

  tlsu_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .op_i(s_axis_tdata[1:0]), .ins_i(s_axis_tdata[17:2]),
    .ridx_i(s_axis_tdata[21:18]), .data_i(s_axis_tdata[53:22]),
    .kind_o(kind), .addr_o(addr), .size_o(size), .wdata_o(wdata),
    .rnum_o(rnum), .rval_o(rval), .last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {rval, rnum, wdata, size, addr, kind};

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("in and out active together");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && m_axis_tlast |=> s_axis_tready) else $error("not idle after last");
`endif

endmodule

// File: sim/tlsu_checker.sv
module tlsu_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [55:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [103:0] m_axis_tdata,
  input  logic         m_axis_tlast,
  output int           fail_count_o,
  output int           outstanding_o
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [1:0]  size;
    logic [31:0] wdata;
    logic [3:0]  rnum;
    logic [31:0] rval;
    logic        last;
  } beat_t;

  logic [31:0] regs [16];
  logic [6:0]  pend_q [tlsu_pkg::QDepth];
  int unsigned pend_cnt, pend_head;
  beat_t exp_beats [$];
  beat_t res [$];
  int fails;

  assign fail_count_o  = fails;
  assign outstanding_o = exp_beats.size();

  function automatic beat_t mk(logic [1:0] k, logic [31:0] a, logic [1:0] s,
                               logic [31:0] w, logic [3:0] r, logic [31:0] v);
    beat_t b;
    b.kind = k; b.addr = a; b.size = s; b.wdata = w; b.rnum = r; b.rval = v;
    b.last = 1'b0;
    return b;
  endfunction

  task automatic reg_wr(logic [3:0] r, logic [31:0] v);
    regs[r] = v;
    res.push_back(mk(tlsu_pkg::KindReg, 0, 0, 0, r, v));
  endtask

  task automatic bus_rd(logic [31:0] a, logic [1:0] s, logic [3:0] r, logic [2:0] c);
    if (pend_cnt < tlsu_pkg::QDepth) begin
      pend_q[(pend_head + pend_cnt) % tlsu_pkg::QDepth] = {c, r};
      pend_cnt++;
    end
    res.push_back(mk(tlsu_pkg::KindRead, a, s, 0, 0, 0));
  endtask

  task automatic bus_wr(logic [31:0] a, logic [1:0] s, logic [31:0] v);
    if (s == tlsu_pkg::SzByte) v &= 32'hFF;
    else if (s == tlsu_pkg::SzHalf) v &= 32'hFFFF;
    res.push_back(mk(tlsu_pkg::KindWrite, a, s, v, 0, 0));
  endtask

  // instruction decode and execution, formats 6 to 15
  task automatic exec_insn(logic [15:0] ins);
    logic [3:0] rd, rb, ro, rd8;
    logic [4:0] off5;
    logic [7:0] w8;
    logic l, bb, base_in;
    logic [31:0] a, pcb, nsp;
    int cnt;
    rd = ins[2:0]; rb = ins[5:3]; ro = ins[8:6]; rd8 = ins[10:8];
    off5 = ins[10:6]; w8 = ins[7:0]; l = ins[11];
    pcb = (regs[15] + 32'd2) & ~32'h3;
    if (ins[15:11] == 5'h09) begin
      bus_rd(pcb + w8 * 4, tlsu_pkg::SzWord, rd8, tlsu_pkg::ExtWord);
    end else if (ins[15:12] == 4'h5 && !ins[9]) begin
      bb = ins[10];
      a = regs[rb] + regs[ro];
      if (l) bus_rd(a, bb ? tlsu_pkg::SzByte : tlsu_pkg::SzWord, rd,
                    bb ? tlsu_pkg::ExtByte : tlsu_pkg::ExtWord);
      else bus_wr(a, bb ? tlsu_pkg::SzByte : tlsu_pkg::SzWord, regs[rd]);
    end else if (ins[15:12] == 4'h5) begin
      a = regs[rb] + regs[ro];
      case ({ins[10], l})
        2'b00: bus_wr(a, tlsu_pkg::SzHalf, regs[rd]);
        2'b01: bus_rd(a, tlsu_pkg::SzHalf, rd, tlsu_pkg::ExtHalf);
        2'b10: bus_rd(a, tlsu_pkg::SzByte, rd, tlsu_pkg::ExtSByte);
        default: bus_rd(a, tlsu_pkg::SzHalf, rd, tlsu_pkg::ExtSHalf);
      endcase
    end else if (ins[15:13] == 3'h3) begin
      bb = ins[12];
      a = regs[rb] + (bb ? off5 : off5 * 4);
      if (l) bus_rd(a, bb ? tlsu_pkg::SzByte : tlsu_pkg::SzWord, rd,
                    bb ? tlsu_pkg::ExtByte : tlsu_pkg::ExtWord);
      else bus_wr(a, bb ? tlsu_pkg::SzByte : tlsu_pkg::SzWord, regs[rd]);
    end else if (ins[15:12] == 4'h8) begin
      a = regs[rb] + off5 * 2;
      if (l) bus_rd(a, tlsu_pkg::SzHalf, rd, tlsu_pkg::ExtHalf);
      else bus_wr(a, tlsu_pkg::SzHalf, regs[rd]);
    end else if (ins[15:12] == 4'h9) begin
      a = regs[13] + w8 * 4;
      if (l) bus_rd(a, tlsu_pkg::SzWord, rd8, tlsu_pkg::ExtWord);
      else bus_wr(a, tlsu_pkg::SzWord, regs[rd8]);
    end else if (ins[15:12] == 4'hA) begin
      a = l ? regs[13] : pcb;
      reg_wr(rd8, a + w8 * 4);
    end else if (ins[15:8] == 8'hB0) begin
      reg_wr(4'd13, ins[7] ? regs[13] - ins[6:0] * 4 : regs[13] + ins[6:0] * 4);
    end else if ((ins & 16'hF600) == 16'hB400) begin
      cnt = ins[8];
      for (int i = 0; i < 8; i++) cnt += w8[i];
      if (l) begin
        a = regs[13];
        for (int i = 0; i < 8; i++) if (w8[i]) begin
          bus_rd(a, tlsu_pkg::SzWord, 4'(i), tlsu_pkg::ExtWord);
          a += 4;
        end
        if (ins[8]) begin
          bus_rd(a, tlsu_pkg::SzWord, 4'd15, tlsu_pkg::ExtPc);
          a += 4;
        end
        reg_wr(4'd13, a);
      end else begin
        nsp = regs[13] - cnt * 4;
        a = nsp;
        for (int i = 0; i < 8; i++) if (w8[i]) begin
          bus_wr(a, tlsu_pkg::SzWord, regs[i]);
          a += 4;
        end
        if (ins[8]) bus_wr(a, tlsu_pkg::SzWord, regs[14]);
        reg_wr(4'd13, nsp);
      end
    end else if (ins[15:12] == 4'hC) begin
      base_in = 1'b0;
      a = regs[rd8];
      for (int i = 0; i < 8; i++) if (w8[i]) begin
        if (l) begin
          bus_rd(a, tlsu_pkg::SzWord, 4'(i), tlsu_pkg::ExtWord);
          if (i == rd8) base_in = 1'b1;
        end else begin
          bus_wr(a, tlsu_pkg::SzWord, regs[i]);
        end
        a += 4;
      end
      if (!(l && base_in)) reg_wr(rd8, a);
    end
  endtask

  // returned read data pops the oldest pending destination
  task automatic read_return(logic [31:0] d);
    logic [6:0] e;
    logic [31:0] v;
    e = pend_q[pend_head];
    pend_head = (pend_head + 1) % tlsu_pkg::QDepth;
    pend_cnt--;
    v = d;
    case (e[6:4])
      tlsu_pkg::ExtByte:  v = d & 32'hFF;
      tlsu_pkg::ExtHalf:  v = d & 32'hFFFF;
      tlsu_pkg::ExtSByte: v = {{24{d[7]}}, d[7:0]};
      tlsu_pkg::ExtSHalf: v = {{16{d[15]}}, d[15:0]};
      tlsu_pkg::ExtPc:    v = d & ~32'h1;
      default:            v = d;
    endcase
    reg_wr(e[3:0], v);
  endtask

  task automatic predict_item(logic [55:0] t);
    logic [1:0] op;
    res.delete();
    op = t[1:0];
    if (op == tlsu_pkg::OpPreload) regs[t[21:18]] = t[53:22];
    else if (op == tlsu_pkg::OpExec) exec_insn(t[17:2]);
    else if (op == tlsu_pkg::OpRdata && pend_cnt > 0) read_return(t[53:22]);
    if (res.size() == 0) res.push_back(mk(tlsu_pkg::KindNone, 0, 0, 0, 0, 0));
    res[res.size() - 1].last = 1'b1;
    foreach (res[i]) exp_beats.push_back(res[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) regs[i] = '0;
      pend_cnt = 0;
      pend_head = 0;
      fails = 0;
      exp_beats.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_item(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[1:0], m_axis_tdata[33:2], m_axis_tdata[35:34],
               m_axis_tdata[67:36], m_axis_tdata[71:68], m_axis_tdata[103:72],
               m_axis_tlast};
        if (exp_beats.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          fails++;
        end else begin
          want = exp_beats.pop_front();
          if (got.kind !== want.kind) begin
            $display("%0t: kind exp %h got %h", $time, want.kind, got.kind); fails++;
          end
          if (got.addr !== want.addr) begin
            $display("%0t: address exp %h got %h", $time, want.addr, got.addr); fails++;
          end
          if (got.size !== want.size) begin
            $display("%0t: size exp %h got %h", $time, want.size, got.size); fails++;
          end
          if (got.wdata !== want.wdata) begin
            $display("%0t: wdata exp %h got %h", $time, want.wdata, got.wdata); fails++;
          end
          if (got.rnum !== want.rnum) begin
            $display("%0t: reg exp %h got %h", $time, want.rnum, got.rnum); fails++;
          end
          if (got.rval !== want.rval) begin
            $display("%0t: value exp %h got %h", $time, want.rval, got.rval); fails++;
          end
          if (got.last !== want.last) begin
            $display("%0t: tlast exp %b got %b", $time, want.last, got.last); fails++;
          end
        end
      end
    end
  end
endmodule

// File: sim/tb_thumb_load_store_unit_top.sv
module tb_thumb_load_store_unit_top;

  logic         clk_i, rst_ni;
  logic         s_axis_tvalid, s_axis_tready;
  logic [55:0]  s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready;
  logic [103:0] m_axis_tdata;
  logic         m_axis_tlast;
  int           fail_count, outstanding;
  int           src_idle, snk_idle;

  thumb_load_store_unit_top dut (.*);

  tlsu_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .fail_count_o(fail_count), .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

  // receiver stall
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_idle);
  end

  function automatic logic [55:0] pack(logic [1:0] op, logic [15:0] ins,
                                       logic [3:0] ri, logic [31:0] d);
    return {2'b00, d, ri, ins, op};
  endfunction

  // one beat, with random sender gaps before it; valid stays up into the next beat
  task automatic send(logic [55:0] t);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= t;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // mostly load/store encodings from the handled formats
  function automatic logic [15:0] rand_insn();
    logic [15:0] r;
    r = 16'($urandom);
    case ($urandom_range(11))
      0: r[15:11] = 5'b01001;
      1: r[15:12] = 4'h5;
      2: r[15:13] = 3'b011;
      3: r[15:12] = 4'h8;
      4: r[15:12] = 4'h9;
      5: r[15:12] = 4'hA;
      6: r[15:8] = 8'hB0;
      7: begin r[15:12] = 4'hB; r[10:9] = 2'b10; end
      8: r[15:12] = 4'hC;
      9: r[15:12] = 4'hC;
      default: ;
    endcase
    return r;
  endfunction

  task automatic rand_item();
    int k;
    k = $urandom_range(9);
    if (k < 2) send(pack(tlsu_pkg::OpPreload, 16'($urandom), 4'($urandom), $urandom));
    else if (k < 6) send(pack(tlsu_pkg::OpExec, rand_insn(), 4'($urandom), $urandom));
    else if (k < 9) send(pack(tlsu_pkg::OpRdata, 16'($urandom), 4'($urandom), $urandom));
    else send(pack(2'd3, 16'($urandom), 4'($urandom), $urandom));
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    src_idle = 27;
    snk_idle = 77;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: preloads, formats 6 to 10 and 12 to 15, extremes, special cases
    send(pack(tlsu_pkg::OpRdata, 0, 0, 32'hFFFFFFFF));        // nothing pending
    send(pack(tlsu_pkg::OpPreload, 0, 4'd13, 32'h0000_1000));
    send(pack(tlsu_pkg::OpPreload, 0, 4'd0, 32'hFFFF_FFFF));
    send(pack(tlsu_pkg::OpPreload, 0, 4'd15, 32'h0000_0101));
    send(pack(tlsu_pkg::OpExec, 16'h4FFF, 0, 0));              // PC-relative load
    send(pack(tlsu_pkg::OpExec, 16'h5000, 0, 0));              // store word reg offset
    send(pack(tlsu_pkg::OpExec, 16'h5400, 0, 0));              // store byte
    send(pack(tlsu_pkg::OpExec, 16'h5600, 0, 0));              // ldrsb
    send(pack(tlsu_pkg::OpExec, 16'h5E00, 0, 0));              // ldrsh
    send(pack(tlsu_pkg::OpRdata, 0, 0, 32'h1234_5680));
    send(pack(tlsu_pkg::OpRdata, 0, 0, 32'h0000_8001));
    send(pack(tlsu_pkg::OpExec, 16'h7FFF, 0, 0));              // ldrb imm
    send(pack(tlsu_pkg::OpExec, 16'h8FFF, 0, 0));              // ldrh imm
    send(pack(tlsu_pkg::OpExec, 16'hA8FF, 0, 0));              // add from SP
    send(pack(tlsu_pkg::OpExec, 16'hB0FF, 0, 0));              // SP adjust down
    send(pack(tlsu_pkg::OpExec, 16'hB5FF, 0, 0));              // push all + LR
    send(pack(tlsu_pkg::OpExec, 16'hBDFF, 0, 0));              // pop all + PC, fills queue
    send(pack(tlsu_pkg::OpExec, 16'hBC00, 0, 0));              // empty pop
    for (int i = 0; i < 4; i++) send(pack(tlsu_pkg::OpRdata, 0, 0, 32'hFFFF_FFFF));
    send(pack(tlsu_pkg::OpExec, 16'hC901, 0, 0));              // ldmia base not in list
    send(pack(tlsu_pkg::OpExec, 16'hC0FF, 0, 0));              // stmia base in list
    send(pack(tlsu_pkg::OpExec, 16'hC800, 0, 0));              // empty ldmia
    send(pack(tlsu_pkg::OpExec, 16'h0000, 0, 0));              // not a load/store
    send(pack(2'd3, 16'hFFFF, 4'hF, 32'hFFFF_FFFF));           // unknown op

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin src_idle = 77; snk_idle = 27; end
      if (ph == 2) begin src_idle = 0; snk_idle = 0; end
      repeat (115) rand_item();
    end
    s_axis_tvalid <= 1'b0;

    while (outstanding != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
